[rtl/inode_cache_refcount_table_top_assert.svh]
// assertion macros used by the inode slot table sequencer
`ifndef INODE_CACHE_REFCOUNT_TABLE_TOP_ASSERT_SVH
`define INODE_CACHE_REFCOUNT_TABLE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ICRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icrt same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define ICRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icrt next-cycle check failed");

`endif

[rtl/icrt_pkg.sv]
// types and constants of the inode slot table
package icrt_pkg;

   localparam logic [15:0] REF_MAX      = 16'hFFFF;
   localparam logic [31:0] BASE_SECTORS = 32'd2;
   localparam int          INODE_W      = 12;

   localparam logic CSR_INODE_MAP  = 1'b0;
   localparam logic CSR_SECTOR_MAP = 1'b1;

   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_HIT       = 3'd0,
      ST_CLAIM     = 3'd1,
      ST_NULL      = 3'd2,
      ST_FULL      = 3'd3,
      ST_UNDERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_REL
   } fsm_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] device;
      logic [11:0] inode_number;
      logic [5:0]  release_slot;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  slot;
      logic [15:0] ref_count;
      logic [31:0] inode_sector;
      logic [11:0] inode_offset;
   } rsp_type;

   // one slot as read from the store
   typedef struct packed {
      logic [15:0] refs;
      logic [15:0] device;
      logic [11:0] inode_number;
   } entry_type;

   // write request into the store
   typedef struct packed {
      logic        ref_we;
      logic        tag_we;
      logic [15:0] refs;
      logic [15:0] device;
      logic [11:0] inode_number;
   } wr_type;

endpackage

[rtl/icrt_store.sv]
// slot store: tag memory and reference count memory, one read and one write port each
module icrt_store #(
   parameter int SLOTS = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic [AW-1:0]       rd_addr,
   input  logic [AW-1:0]       wr_addr,
   input  icrt_pkg::wr_type    wr,
   output icrt_pkg::entry_type rd
);

   logic [27:0] tag_mem_ff [SLOTS];
   logic [15:0] ref_mem_ff [SLOTS];
   logic [27:0] tag_rd_ff;
   logic [15:0] ref_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.tag_we) begin
         tag_mem_ff[wr_addr] <= {wr.device, wr.inode_number};
      end
      tag_rd_ff <= tag_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.ref_we) begin
         ref_mem_ff[wr_addr] <= wr.refs;
      end
      ref_rd_ff <= ref_mem_ff[rd_addr];
   end

   assign rd.refs         = ref_rd_ff;
   assign rd.device       = tag_rd_ff[27:12];
   assign rd.inode_number = tag_rd_ff[11:0];

endmodule

[rtl/icrt_addr.sv]
// disk location of an inode record: quotient by reciprocal, then sector and offset
module icrt_addr #(
   parameter int SECTOR_BYTES = 512,
   parameter int INODE_BYTES  = 32
) (
   input  logic        clock,
   input  logic [11:0] inode_number,
   input  logic [15:0] inode_map_sectors,
   input  logic [15:0] sector_map_sectors,
   output logic [31:0] inode_sector,
   output logic [11:0] inode_offset
);

   localparam int    PER_RAW = SECTOR_BYTES / INODE_BYTES;
   localparam int    PER     = (PER_RAW == 0) ? 1 : PER_RAW;
   localparam int    PER_SH  = $clog2(PER);
   localparam int    SH      = icrt_pkg::INODE_W + PER_SH;
   // rounded-up reciprocal, exact for every 12-bit dividend
   localparam longint RECIP  = ((longint'(1) << SH) + longint'(PER) - 1) / longint'(PER);
   localparam int    SPAN    = PER * INODE_BYTES;

   logic [11:0] idx;
   logic [25:0] prod;
   logic [11:0] idx_ff;
   logic [11:0] q_ff;
   logic [11:0] q_in;
   logic [25:0] byte_pos;
   logic [25:0] sec_start;

   assign idx  = inode_number - 12'd1;
   assign prod = 26'(idx) * 26'(RECIP);
   assign q_in = 12'(prod >> SH);

   always_ff @(posedge clock) begin
      idx_ff <= idx;
      q_ff   <= q_in;
   end

   assign byte_pos  = 26'(idx_ff) * 26'(INODE_BYTES);
   assign sec_start = 26'(q_ff) * 26'(SPAN);

   assign inode_sector = icrt_pkg::BASE_SECTORS + 32'(inode_map_sectors)
                       + 32'(sector_map_sectors) + 32'(q_ff);
   assign inode_offset = 12'(byte_pos - sec_start);

endmodule

[rtl/icrt_ctrl.sv]
// sequencer: clearing pass, slot scan, release and claim, result register
`include "inode_cache_refcount_table_top_assert.svh"
module icrt_ctrl #(
   parameter int SLOTS = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  icrt_pkg::req_type   req_item,
   output logic                busy,
   output logic                rsp_strobe,
   output icrt_pkg::rsp_type   rsp_item,
   output logic [AW-1:0]       rd_addr,
   output logic [AW-1:0]       wr_addr,
   output icrt_pkg::wr_type    wr,
   input  icrt_pkg::entry_type rd,
   output logic [11:0]         claim_inode,
   input  logic [31:0]         inode_sector,
   input  logic [11:0]         inode_offset
);

   localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

   icrt_pkg::fsm_type state_ff, state_in;
   icrt_pkg::req_type req_ff, req_in;
   icrt_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     free_ff, free_in;
   logic              have_free_ff, have_free_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              accept;
   logic              cur_free;
   logic              match;
   logic [AW-1:0]     claim_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= icrt_pkg::FSM_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      idx_ff       <= idx_in;
      free_ff      <= free_in;
      have_free_ff <= have_free_in;
   end

   assign busy        = (state_ff != icrt_pkg::FSM_IDLE);
   assign accept      = start && !busy;
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_item    = rsp_ff;
   assign claim_inode = req_ff.inode_number;

   assign cur_free  = (rd.refs == 16'd0);
   assign match     = !cur_free && (rd.device == req_ff.device)
                    && (rd.inode_number == req_ff.inode_number);
   assign claim_idx = have_free_ff ? free_ff : idx_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      idx_in       = idx_ff;
      free_in      = free_ff;
      have_free_in = have_free_ff;
      clr_in       = clr_ff;
      rd_addr      = '0;
      wr_addr      = '0;
      wr           = '0;
      case (state_ff)
         icrt_pkg::FSM_CLEAR: begin
            wr.ref_we = 1'b1;
            wr_addr   = clr_ff;
            if (clr_ff == LAST) begin
               state_in = icrt_pkg::FSM_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         icrt_pkg::FSM_IDLE: begin
            if (accept) begin
               req_in = req_item;
               rsp_in = '0;
               if (req_item.kind == icrt_pkg::KIND_RELEASE) begin
                  rd_addr = AW'(req_item.release_slot);
                  if (int'(req_item.release_slot) < SLOTS) begin
                     state_in = icrt_pkg::FSM_REL;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = icrt_pkg::ST_UNDERFLOW;
                     rsp_in.slot   = req_item.release_slot;
                  end
               end else if (req_item.inode_number == 12'd0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = icrt_pkg::ST_NULL;
               end else begin
                  idx_in       = '0;
                  have_free_in = 1'b0;
                  free_in      = '0;
                  state_in     = icrt_pkg::FSM_SCAN;
               end
            end
         end
         icrt_pkg::FSM_REL: begin
            state_in     = icrt_pkg::FSM_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.slot  = req_ff.release_slot;
            if (cur_free) begin
               rsp_in.status = icrt_pkg::ST_UNDERFLOW;
            end else begin
               wr.ref_we        = 1'b1;
               wr.refs          = rd.refs - 16'd1;
               wr_addr          = AW'(req_ff.release_slot);
               rsp_in.status    = icrt_pkg::ST_HIT;
               rsp_in.ref_count = rd.refs - 16'd1;
            end
         end
         icrt_pkg::FSM_SCAN: begin
            // read of the next slot goes out while this one is judged
            rd_addr = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (match) begin
               wr.ref_we        = 1'b1;
               wr.refs          = (rd.refs == icrt_pkg::REF_MAX) ? rd.refs
                                                                 : rd.refs + 16'd1;
               wr_addr          = idx_ff;
               state_in         = icrt_pkg::FSM_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_in.status    = icrt_pkg::ST_HIT;
               rsp_in.slot      = 6'(idx_ff);
               rsp_in.ref_count = wr.refs;
            end else begin
               if (cur_free && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = idx_ff;
               end
               if (idx_ff == LAST) begin
                  state_in     = icrt_pkg::FSM_IDLE;
                  rsp_valid_in = 1'b1;
                  if (have_free_ff || cur_free) begin
                     wr.ref_we           = 1'b1;
                     wr.tag_we           = 1'b1;
                     wr.refs             = 16'd1;
                     wr.device           = req_ff.device;
                     wr.inode_number     = req_ff.inode_number;
                     wr_addr             = claim_idx;
                     rsp_in.status       = icrt_pkg::ST_CLAIM;
                     rsp_in.slot         = 6'(claim_idx);
                     rsp_in.ref_count    = 16'd1;
                     rsp_in.inode_sector = inode_sector;
                     rsp_in.inode_offset = inode_offset;
                  end else begin
                     rsp_in.status = icrt_pkg::ST_FULL;
                  end
               end
            end
         end
         default: begin
            state_in = icrt_pkg::FSM_IDLE;
         end
      endcase
   end

   `ICRT_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid_ff)
   `ICRT_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == icrt_pkg::FSM_IDLE)
   `ICRT_ASSERT_NEXT(a_scan_write_ends, clock, reset, (state_ff == icrt_pkg::FSM_SCAN) && wr.ref_we, state_ff == icrt_pkg::FSM_IDLE)
   `ICRT_ASSERT_NEXT(a_release_one_cycle, clock, reset, state_ff == icrt_pkg::FSM_REL, (state_ff == icrt_pkg::FSM_IDLE) && rsp_valid_ff)

endmodule

[rtl/inode_cache_refcount_table_top.sv]
// inode slot table with reference counts and first-free claim
//
// Request channel: start with req_item; a transfer happens at a clock edge
// where start is high and busy is low. kind selects acquire or release.
// Result channel: rsp_item is valid for exactly one cycle while rsp_strobe
// is high; the receiver has no way to stall it, one result per request.
// Register port: csr_we, csr_index, csr_wdata, written at the clock edge.
// Write only while the block is idle; the block itself does not enforce it.
// A null inode or an out-of-range release is answered straight from the
// request; a release first reads its slot; an acquire ends at a hit or, for
// a claim or a full table, after the last slot. The acquire scan walks the
// count and tag memories one slot per cycle, so a miss holds busy through
// the whole table. Reset is synchronous; afterwards a clearing pass zeroes
// every count, one slot per cycle, with busy high. Register writes are
// taken during that pass.
module inode_cache_refcount_table_top #(
   parameter int SLOTS        = 64,
   parameter int SECTOR_BYTES = 512,
   parameter int INODE_BYTES  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  icrt_pkg::req_type req_item,
   output logic              rsp_strobe,
   output icrt_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int AW = $clog2(SLOTS);

   logic [15:0]         inode_map_ff;
   logic [15:0]         sector_map_ff;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   icrt_pkg::wr_type    wr;
   icrt_pkg::entry_type rd;
   logic [11:0]         claim_inode;
   logic [31:0]         inode_sector;
   logic [11:0]         inode_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_map_ff  <= 16'd1;
         sector_map_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            icrt_pkg::CSR_INODE_MAP:  inode_map_ff  <= csr_wdata;
            icrt_pkg::CSR_SECTOR_MAP: sector_map_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   icrt_ctrl #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_item     (req_item),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .wr           (wr),
      .rd           (rd),
      .claim_inode  (claim_inode),
      .inode_sector (inode_sector),
      .inode_offset (inode_offset)
   );

   icrt_store #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr      (wr),
      .rd      (rd)
   );

   icrt_addr #(
      .SECTOR_BYTES (SECTOR_BYTES),
      .INODE_BYTES  (INODE_BYTES)
   ) u_addr (
      .clock              (clock),
      .inode_number       (claim_inode),
      .inode_map_sectors  (inode_map_ff),
      .sector_map_sectors (sector_map_ff),
      .inode_sector       (inode_sector),
      .inode_offset       (inode_offset)
   );

endmodule
